// ===== rtl/core/stereo_band_descriptor_matcher_defines.svh =====
// assertion macros for the stereo band descriptor matcher
`ifndef STEREO_BAND_DESCRIPTOR_MATCHER_DEFINES_SVH
`define STEREO_BAND_DESCRIPTOR_MATCHER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SBDM_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("sbdm check failed");
`define SBDM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbdm check failed");
`else
`define SBDM_ASSERT(lbl, cond)
`define SBDM_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/sbdm_pkg.sv =====
// shared types, constants and functions of the band descriptor matcher
`timescale 1ns / 1ps
`default_nettype none
package sbdm_pkg;
  localparam int MAX_ENTRIES_DEF = 4096;
  localparam int DESC_BITS_DEF   = 256;
  localparam int IN_WORDS        = 4;
  localparam int POS_W           = 15;
  localparam int TAG_W           = 16;
  localparam int HH_W            = 14;
  localparam int THR_W           = 9;
  localparam int HD_W            = 9;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;
  localparam logic [HH_W-1:0]  HH_RESET  = 14'd640;
  localparam logic [THR_W-1:0] THR_RESET = 9'd40;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd1;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FRONT_RD,
    S_FRONT_CHK,
    S_FILL_RD,
    S_FILL_CHK,
    S_SCAN,
    S_DRAIN,
    S_BEST_RD,
    S_RESULT
  } sbdm_state_t;

  // valid bits of descriptor word w for a descriptor of nbits bits
  function automatic logic [63:0] word_mask(input int nbits, input int w);
    int left;
    begin
      left = nbits - 64 * w;
      if (left <= 0) word_mask = '0;
      else if (left >= 64) word_mask = '1;
      else word_mask = (64'd1 << left) - 64'd1;
    end
  endfunction

  function automatic logic [6:0] popcount64(input logic [63:0] v);
    logic [6:0] n;
    begin
      n = '0;
      for (int i = 0; i < 64; i++) n = n + 7'(v[i]);
      popcount64 = n;
    end
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/sbdm_ifs.sv =====
// handshake channel interfaces: request, result and register write
`timescale 1ns / 1ps
`default_nettype none
interface sbdm_in_if import sbdm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic             new_frame;
  logic [POS_W-1:0] y_pos;
  logic [POS_W-1:0] x_pos;
  logic [TAG_W-1:0] point_tag;
  logic [63:0]      desc_word0;
  logic [63:0]      desc_word1;
  logic [63:0]      desc_word2;
  logic [63:0]      desc_word3;
  modport source (output valid, req_type, new_frame, y_pos, x_pos, point_tag,
                  desc_word0, desc_word1, desc_word2, desc_word3, input ready);
  modport sink (input valid, req_type, new_frame, y_pos, x_pos, point_tag,
                desc_word0, desc_word1, desc_word2, desc_word3, output ready);
endinterface

interface sbdm_out_if import sbdm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             matched;
  logic [TAG_W-1:0] query_tag;
  logic [TAG_W-1:0] right_tag;
  logic [HD_W-1:0]  hamming_distance;
  logic [POS_W-1:0] disparity;
  modport source (output valid, matched, query_tag, right_tag, hamming_distance,
                  disparity, input ready);
  modport sink (input valid, matched, query_tag, right_tag, hamming_distance,
                disparity, output ready);
endinterface

interface sbdm_cfg_if import sbdm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sbdm_cell.sv =====
// one descriptor word cell: word store, xor popcount, partial sum hand-off
`timescale 1ns / 1ps
`default_nettype none
module sbdm_cell import sbdm_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int DESC_BITS   = DESC_BITS_DEF,
  parameter int CELL_IDX    = 0,
  parameter int AW          = $clog2(MAX_ENTRIES),
  parameter int DIST_W      = $clog2(DESC_BITS + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [63:0]       wr_word,
  input  wire logic              q_load,
  input  wire logic [63:0]       q_word,
  input  wire logic              in_valid,
  input  wire logic              in_elig,
  input  wire logic [AW-1:0]     in_addr,
  input  wire logic [DIST_W-1:0] in_sum,
  output logic                   out_valid,
  output logic                   out_elig,
  output logic [AW-1:0]          out_addr,
  output logic [DIST_W-1:0]      out_sum
);
  localparam logic [63:0] MASK = word_mask(DESC_BITS, CELL_IDX);

  logic [63:0]       mem [MAX_ENTRIES];
  logic [63:0]       q_r;
  logic [63:0]       rd_r;
  logic              a_valid_r;
  logic              a_elig_r;
  logic [AW-1:0]     a_addr_r;
  logic [DIST_W-1:0] a_sum_r;
  logic              b_valid_r;
  logic              b_elig_r;
  logic [AW-1:0]     b_addr_r;
  logic [DIST_W-1:0] b_sum_r;
  logic [DIST_W-1:0] b_sum_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_word & MASK;
    rd_r <= mem[in_addr];
  end

  always_ff @(posedge clk) begin
    if (q_load) q_r <= q_word & MASK;
  end

  assign b_sum_nxt = a_sum_r + DIST_W'(popcount64((rd_r ^ q_r) & MASK));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
    end
    a_elig_r <= in_elig;
    a_addr_r <= in_addr;
    a_sum_r  <= in_sum;
    b_elig_r <= a_elig_r;
    b_addr_r <= a_addr_r;
    b_sum_r  <= b_sum_nxt;
  end

  assign out_valid = b_valid_r;
  assign out_elig  = b_elig_r;
  assign out_addr  = b_addr_r;
  assign out_sum   = b_sum_r;
endmodule
`default_nettype wire

// ===== rtl/core/stereo_band_descriptor_matcher.sv =====
// top level of the epipolar band hamming descriptor matcher
// usage:
//   in_ch carries items: req_type 0 loads a right keypoint (position, tag,
//   descriptor) into the store, req_type 1 queries with a left keypoint.
//   loads and queries must come in ascending y; the block does not check it.
//   new_frame on a load empties the store first. out_ch gives one item per
//   query only. cfg_ch writes window_half_height (index 0) and match_threshold
//   (index 1), taken at any time, meant only while the block is idle.
// query sequence:
//   a load is written as it is accepted. a query walks the front pointer
//   and then the fill pointer, each step a read state and a check state,
//   scans the band with one read of the entry memories a cycle feeding the
//   chain of word cells, then drains the cell chain and fetches the winner.
//   one query is worked on at a time.
// reset: registers take their reset values, store pointers and count go to
//   zero; store memories need no clearing since entries are read only below
//   the count and a load clears the consumed mark of its entry.
// stall: a result sits in the output register until taken; the next item is
//   accepted meanwhile, and a later query waits only at its own result.
`timescale 1ns / 1ps
`default_nettype none
module stereo_band_descriptor_matcher import sbdm_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int DESC_BITS   = DESC_BITS_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  sbdm_in_if.sink    in_ch,
  sbdm_out_if.source out_ch,
  sbdm_cfg_if.sink   cfg_ch
);
`include "stereo_band_descriptor_matcher_defines.svh"

  localparam int AW        = $clog2(MAX_ENTRIES);
  localparam int CW        = $clog2(MAX_ENTRIES + 1);
  localparam int DW        = (DESC_BITS + 63) / 64;
  localparam int DIST_W    = $clog2(DESC_BITS + 1);
  localparam int CMP_W     = DIST_W + THR_W;
  localparam int DRAIN_CYC = 2 * DW + 2;
  localparam int WT_W      = $clog2(DRAIN_CYC + 1);

  // registers and pointers
  sbdm_state_t       state_r, state_nxt;
  logic [HH_W-1:0]   hh_r;
  logic [THR_W-1:0]  thr_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     front_r, front_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [CW-1:0]     scan_r, scan_nxt;
  logic [WT_W-1:0]   wait_r, wait_nxt;
  logic [POS_W-1:0]  qy_r, qx_r;
  logic [TAG_W-1:0]  qtag_r;
  logic              best_found_r;
  logic [DIST_W-1:0] win_dist_r;
  logic [AW-1:0]     win_idx_r;
  logic              issue_v_r, issue_v_nxt;
  logic [AW-1:0]     issue_addr_r;

  // entry memories
  logic [POS_W-1:0]  mem_y [MAX_ENTRIES];
  logic [POS_W-1:0]  mem_x [MAX_ENTRIES];
  logic [TAG_W-1:0]  mem_tag [MAX_ENTRIES];
  logic              mem_cons [MAX_ENTRIES];
  logic [POS_W-1:0]  rd_y_r, rd_x_r;
  logic [TAG_W-1:0]  rd_tag_r;
  logic              rd_cons_r;
  logic [AW-1:0]     rd_addr_c;

  // output register
  logic              out_valid_r;
  logic              out_matched_r;
  logic [TAG_W-1:0]  out_qtag_r, out_rtag_r;
  logic [HD_W-1:0]   out_dist_r;
  logic [POS_W-1:0]  out_disp_r;

  logic              in_fire, load_fire, query_fire;
  logic [CW-1:0]     base_c;
  logic              wr_ok;
  logic              res_load;
  logic              matched_c;
  logic [15:0]       band_lo_c, band_hi_c;

  // cell chain links
  logic              ch_valid [DW+1];
  logic              ch_elig [DW+1];
  logic [AW-1:0]     ch_addr [DW+1];
  logic [DIST_W-1:0] ch_sum [DW+1];
  logic [63:0]       in_word [IN_WORDS];

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign load_fire   = in_fire && (in_ch.req_type == REQ_LOAD);
  assign query_fire  = in_fire && (in_ch.req_type == REQ_QUERY);
  assign base_c      = in_ch.new_frame ? '0 : count_r;
  assign wr_ok       = base_c < CW'(MAX_ENTRIES);

  // band bounds in 16 bits: entry below band when y + hh < qy
  assign band_lo_c = {1'b0, rd_y_r} + {2'b0, hh_r};
  assign band_hi_c = {1'b0, qy_r} + {2'b0, hh_r};

  assign matched_c = best_found_r && (CMP_W'(win_dist_r) < CMP_W'(thr_r));

  // configuration writes, always ready
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hh_r  <= HH_RESET;
      thr_r <= THR_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_HALF_HEIGHT: hh_r  <= cfg_ch.data[HH_W-1:0];
        REG_THRESHOLD:   thr_r <= cfg_ch.data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer: front walk, fill walk, band scan, drain, result
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    front_nxt   = front_r;
    fill_nxt    = fill_r;
    scan_nxt    = scan_r;
    wait_nxt    = wait_r;
    issue_v_nxt = 1'b0;
    rd_addr_c   = win_idx_r;
    res_load    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (load_fire) begin
          if (in_ch.new_frame) begin
            front_nxt = '0;
            fill_nxt  = '0;
          end
          count_nxt = wr_ok ? base_c + CW'(1) : base_c;
        end else if (query_fire) begin
          state_nxt = S_FRONT_RD;
        end
      end
      S_FRONT_RD: begin
        rd_addr_c = front_r[AW-1:0];
        state_nxt = (front_r < fill_r) ? S_FRONT_CHK : S_FILL_RD;
      end
      S_FRONT_CHK: begin
        if (rd_cons_r || (band_lo_c < {1'b0, qy_r})) begin
          front_nxt = front_r + CW'(1);
          state_nxt = S_FRONT_RD;
        end else begin
          state_nxt = S_FILL_RD;
        end
      end
      S_FILL_RD: begin
        rd_addr_c = fill_r[AW-1:0];
        if (fill_r < count_r) begin
          state_nxt = S_FILL_CHK;
        end else begin
          scan_nxt  = front_r;
          state_nxt = S_SCAN;
        end
      end
      S_FILL_CHK: begin
        if ({1'b0, rd_y_r} <= band_hi_c) begin
          fill_nxt  = fill_r + CW'(1);
          state_nxt = S_FILL_RD;
        end else begin
          scan_nxt  = front_r;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_addr_c = scan_r[AW-1:0];
        if (scan_r < fill_r) begin
          issue_v_nxt = 1'b1;
          scan_nxt    = scan_r + CW'(1);
        end else begin
          wait_nxt  = WT_W'(DRAIN_CYC);
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (wait_r == '0) state_nxt = S_BEST_RD;
        else wait_nxt = wait_r - WT_W'(1);
      end
      S_BEST_RD: begin
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_r || out_ch.ready) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      front_r   <= '0;
      fill_r    <= '0;
      scan_r    <= '0;
      wait_r    <= '0;
      issue_v_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      front_r   <= front_nxt;
      fill_r    <= fill_nxt;
      scan_r    <= scan_nxt;
      wait_r    <= wait_nxt;
      issue_v_r <= issue_v_nxt;
    end
  end

  // query capture
  always_ff @(posedge clk) begin
    if (query_fire) begin
      qy_r   <= in_ch.y_pos;
      qx_r   <= in_ch.x_pos;
      qtag_r <= in_ch.point_tag;
    end
    issue_addr_r <= scan_r[AW-1:0];
  end

  // entry memories: load writes, one shared read address
  always_ff @(posedge clk) begin
    if (load_fire && wr_ok) begin
      mem_y[base_c[AW-1:0]]   <= in_ch.y_pos;
      mem_x[base_c[AW-1:0]]   <= in_ch.x_pos;
      mem_tag[base_c[AW-1:0]] <= in_ch.point_tag;
    end
    rd_y_r   <= mem_y[rd_addr_c];
    rd_x_r   <= mem_x[rd_addr_c];
    rd_tag_r <= mem_tag[rd_addr_c];
  end

  // consumed marks: cleared by the entry's load, set by a match
  always_ff @(posedge clk) begin
    if (load_fire && wr_ok) mem_cons[base_c[AW-1:0]] <= 1'b0;
    else if (res_load && matched_c) mem_cons[win_idx_r] <= 1'b1;
    rd_cons_r <= mem_cons[rd_addr_c];
  end

  // descriptor cell chain, one cell per 64-bit word
  assign in_word[0] = in_ch.desc_word0;
  assign in_word[1] = in_ch.desc_word1;
  assign in_word[2] = in_ch.desc_word2;
  assign in_word[3] = in_ch.desc_word3;

  assign ch_valid[0] = issue_v_r;
  assign ch_elig[0]  = !rd_cons_r && (rd_x_r >= qx_r);
  assign ch_addr[0]  = issue_addr_r;
  assign ch_sum[0]   = '0;

  for (genvar k = 0; k < DW; k++) begin : g_cell
    logic [63:0] word_k;
    if (k < IN_WORDS) begin : g_word
      assign word_k = in_word[k];
    end else begin : g_zero
      assign word_k = '0;
    end
    sbdm_cell #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .DESC_BITS   (DESC_BITS),
      .CELL_IDX    (k),
      .AW          (AW),
      .DIST_W      (DIST_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .wr_en     (load_fire && wr_ok),
      .wr_addr   (base_c[AW-1:0]),
      .wr_word   (word_k),
      .q_load    (query_fire),
      .q_word    (word_k),
      .in_valid  (ch_valid[k]),
      .in_elig   (ch_elig[k]),
      .in_addr   (ch_addr[k]),
      .in_sum    (ch_sum[k]),
      .out_valid (ch_valid[k+1]),
      .out_elig  (ch_elig[k+1]),
      .out_addr  (ch_addr[k+1]),
      .out_sum   (ch_sum[k+1])
    );
  end

  // running best: strict less keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_found_r <= 1'b0;
    end else if (query_fire) begin
      best_found_r <= 1'b0;
    end else if (ch_valid[DW] && ch_elig[DW] &&
                 (!best_found_r || (ch_sum[DW] < win_dist_r))) begin
      best_found_r <= 1'b1;
    end
    if (!query_fire && ch_valid[DW] && ch_elig[DW] &&
        (!best_found_r || (ch_sum[DW] < win_dist_r))) begin
      win_dist_r <= ch_sum[DW];
      win_idx_r  <= ch_addr[DW];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_load) begin
      out_matched_r <= matched_c;
      out_qtag_r    <= qtag_r;
      out_rtag_r    <= matched_c ? rd_tag_r : '0;
      out_dist_r    <= matched_c ? HD_W'(win_dist_r) : '0;
      out_disp_r    <= matched_c ? rd_x_r - qx_r : '0;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.matched          = out_matched_r;
  assign out_ch.query_tag        = out_qtag_r;
  assign out_ch.right_tag        = out_rtag_r;
  assign out_ch.hamming_distance = out_dist_r;
  assign out_ch.disparity        = out_disp_r;

  `SBDM_ASSERT(a_front_le_fill, front_r <= fill_r)
  `SBDM_ASSERT(a_fill_le_count, fill_r <= count_r)
  `SBDM_ASSERT_IMP(a_chain_in_query, ch_valid[DW], state_r == S_SCAN || state_r == S_DRAIN)
  `SBDM_ASSERT_IMP(a_result_from_seq, $rose(out_valid_r), $past(state_r) == S_RESULT)
endmodule
`default_nettype wire
